/* sv/ssa_pkg.sv */
// ssa_pkg: shared types and constants for the sweep stack averager.
// No dependencies; imported by every module of the block.
package ssa_pkg;

	localparam int MAX_POINTS_DEF   = 512;
	localparam int MAX_CHANNELS_DEF = 8;

	localparam int SAMPLE_W  = 32;
	localparam int IDX_W     = 12;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int PTS_CFG_W = 10;
	localparam int CH_CFG_W  = 4;
	localparam int SW_CFG_W  = 16;

	localparam logic [PTS_CFG_W-1:0] PTS_RST = PTS_CFG_W'(512);
	localparam logic [CH_CFG_W-1:0]  CH_RST  = CH_CFG_W'(1);
	localparam logic [SW_CFG_W-1:0]  SW_RST  = SW_CFG_W'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POINTS   = 2'd0,
		REG_CHANNELS = 2'd1,
		REG_SWEEPS   = 2'd2,
		REG_ALT      = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic clr_en;
		logic take;
		logic commit;
	} ssa_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic div_done;
		logic emit;
		logic out_full;
	} ssa_status_t;

endpackage

/* sv/ssa_div.sv */
// ssa_div: iterative signed-by-unsigned divider, one quotient bit per cycle.
// Truncates toward zero. Depends on ssa_pkg.
module ssa_div import ssa_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [SAMPLE_W-1:0] dividend,
	input  logic [SW_CFG_W-1:0] divisor,
	output logic [SAMPLE_W-1:0] quotient,
	output logic                done
);

	localparam int CNT_W = $clog2(SAMPLE_W);

	logic                busy_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                neg_q;
	logic [SAMPLE_W-1:0] quo_q;
	logic [SW_CFG_W-1:0] rem_q;
	logic [SW_CFG_W-1:0] dvs_q;
	logic [SW_CFG_W:0]   shifted;
	logic [SW_CFG_W+1:0] trial;

	assign shifted  = {rem_q, quo_q[SAMPLE_W-1]};
	assign trial    = {1'b0, shifted} - {2'b00, dvs_q};
	assign done     = busy_q && (cnt_q == CNT_W'(SAMPLE_W-1));
	assign quotient = neg_q ? (SAMPLE_W'(0) - quo_q) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (done) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SAMPLE_W-1];
			quo_q <= dividend[SAMPLE_W-1] ? (SAMPLE_W'(0) - dividend) : dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SAMPLE_W-2:0], ~trial[SW_CFG_W+1]};
			rem_q <= trial[SW_CFG_W+1] ? shifted[SW_CFG_W-1:0] : trial[SW_CFG_W-1:0];
		end
	end

endmodule

/* sv/ssa_ctrl.sv */
// ssa_ctrl: sequencing state machine for the sweep stack averager.
// Depends on ssa_pkg; drives the datapath through ssa_cmd_t.
module ssa_ctrl import ssa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  ssa_status_t status,
	output ssa_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_DIV   = 4'b0100,
		ST_UPD   = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd        = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (status.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
				if (in_valid) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (status.div_done) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				if (!(status.emit && status.out_full)) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* sv/ssa_dp.sv */
// ssa_dp: configuration registers, position and sweep tracking, accumulator
// memory and output register. Depends on ssa_pkg and ssa_div.
module ssa_dp import ssa_pkg::*; #(
	parameter int MAX_POINTS   = MAX_POINTS_DEF,
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic [SAMPLE_W-1:0]  sample,
	input  ssa_cmd_t             cmd,
	output ssa_status_t          status,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [SAMPLE_W-1:0]  sum_word,
	output logic [IDX_W-1:0]     word_index,
	output logic                 frame_last
);

	localparam int DEPTH = MAX_POINTS * MAX_CHANNELS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FLW   = $clog2(DEPTH + 1);
	localparam int PW    = $clog2(MAX_POINTS + 1);
	localparam int CW    = $clog2(MAX_CHANNELS + 1);

	logic [PTS_CFG_W-1:0] points_q;
	logic [CH_CFG_W-1:0]  chans_q;
	logic [SW_CFG_W-1:0]  sweeps_q;
	logic                 alt_q;

	logic [PW-1:0]        pts_c;
	logic [CW-1:0]        chs_c;
	logic [PW+CW-1:0]     prod_c;
	logic [SW_CFG_W-1:0]  sweeps_c;
	logic [FLW-1:0]       frame_len_c;

	logic [AW-1:0]        pos_q;
	logic [SW_CFG_W-1:0]  sc_q;
	logic [AW-1:0]        idx_c;
	logic                 last_c;
	logic                 final_c;

	logic [AW-1:0]        idx_q;
	logic                 last_q;
	logic                 final_q;
	logic                 sub_q;

	logic [SAMPLE_W-1:0]  mem [DEPTH];
	logic [SAMPLE_W-1:0]  rd_q;
	logic [AW-1:0]        clr_cnt_q;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [SAMPLE_W-1:0]  wr_data;
	logic [SAMPLE_W-1:0]  acc_new;

	logic [SAMPLE_W-1:0]  quotient;
	logic                 div_done;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_q <= PTS_RST;
			chans_q  <= CH_RST;
			sweeps_q <= SW_RST;
			alt_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_POINTS:   points_q <= cfg_data[PTS_CFG_W-1:0];
				REG_CHANNELS: chans_q  <= cfg_data[CH_CFG_W-1:0];
				REG_SWEEPS:   sweeps_q <= cfg_data[SW_CFG_W-1:0];
				REG_ALT:      alt_q    <= cfg_data[0];
			endcase
		end
	end

	always_comb begin
		if (points_q == '0) begin
			pts_c = PW'(1);
		end else if (32'(points_q) > 32'(MAX_POINTS)) begin
			pts_c = PW'(MAX_POINTS);
		end else begin
			pts_c = PW'(points_q);
		end
		if (chans_q == '0) begin
			chs_c = CW'(1);
		end else if (32'(chans_q) > 32'(MAX_CHANNELS)) begin
			chs_c = CW'(MAX_CHANNELS);
		end else begin
			chs_c = CW'(chans_q);
		end
	end

	assign prod_c      = {{CW{1'b0}}, pts_c} * {{PW{1'b0}}, chs_c};
	assign sweeps_c    = (sweeps_q == '0) ? SW_CFG_W'(1) : sweeps_q;
	assign frame_len_c = FLW'(prod_c);

	// position and sweep tracking
	assign idx_c   = (FLW'(pos_q) >= frame_len_c) ? '0 : pos_q;
	assign last_c  = (FLW'(idx_c) + FLW'(1)) == frame_len_c;
	assign final_c = ({1'b0, sc_q} + 17'd1) >= {1'b0, sweeps_c};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sc_q  <= '0;
		end else if (cmd.take) begin
			pos_q <= last_c ? '0 : AW'(idx_c + 1'b1);
			if (last_c) begin
				sc_q <= final_c ? '0 : sc_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			idx_q   <= idx_c;
			last_q  <= last_c;
			final_q <= final_c;
			sub_q   <= alt_q & sc_q[0];
		end
	end

	ssa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.take),
		.dividend (sample),
		.divisor  (sweeps_c),
		.quotient (quotient),
		.done     (div_done)
	);

	// accumulator memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_en) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	assign acc_new = sub_q ? (rd_q - quotient) : (rd_q + quotient);
	assign wr_en   = cmd.clr_en | cmd.commit;
	assign wr_addr = cmd.clr_en ? clr_cnt_q : idx_q;
	assign wr_data = (cmd.clr_en || final_q) ? '0 : acc_new;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.take) begin
			rd_q <= mem[idx_c];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.commit && final_q) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && final_q) begin
			sum_word   <= acc_new;
			word_index <= IDX_W'(idx_q);
			frame_last <= last_q;
		end
	end

	assign status.clr_last = clr_cnt_q == AW'(DEPTH - 1);
	assign status.div_done = div_done;
	assign status.emit     = final_q;
	assign status.out_full = out_valid & ~out_ready;

endmodule

/* sv/sweep_stack_averager.sv */
// sweep_stack_averager: top level, joins ssa_ctrl and ssa_dp.
// Depends on ssa_pkg, ssa_ctrl, ssa_dp (and ssa_div below it).
//
//   channel  signals                               role
//   in       in_valid, in_ready, sample            one sample item
//   out      out_valid, out_ready, sum_word,       one finished sum item
//            word_index, frame_last
//   cfg      cfg_we, cfg_index, cfg_data           register write, no wait
//
// Each item is accepted, goes through the bit-serial divider, then through a
// read-modify-write on the accumulator memory before the next item is taken.
// After reset the accumulator memory is swept to zero, one entry per cycle,
// all MAX_POINTS * MAX_CHANNELS entries, with in_ready low.
// A new item is taken while a result waits in the output register; the
// update stalls only when it has a result and that register is still full.
module sweep_stack_averager import ssa_pkg::*; #(
	parameter int MAX_POINTS   = MAX_POINTS_DEF,
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [SAMPLE_W-1:0]  sample,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [SAMPLE_W-1:0]  sum_word,
	output logic [IDX_W-1:0]     word_index,
	output logic                 frame_last
);

	ssa_cmd_t    cmd;
	ssa_status_t status;

	ssa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	ssa_dp #(
		.MAX_POINTS   (MAX_POINTS),
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample     (sample),
		.cmd        (cmd),
		.status     (status),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.sum_word   (sum_word),
		.word_index (word_index),
		.frame_last (frame_last)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while previous item in flight");

	a_out_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.commit && status.emit))
		else $error("result raised without a final-sweep commit");

	a_no_accept_mid_div: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> !in_ready)
		else $error("input ready while divider finishing");

endmodule

/* dv/tb_top.sv */
// tb_top: self-checking testbench for sweep_stack_averager.
// Depends on ssa_pkg and the sweep_stack_averager RTL. A scoreboard class keeps its own
// copy of the accumulators and checks every finished sum that leaves the block.
module tb_top;
	import ssa_pkg::*;

	localparam int ACC_DEPTH      = MAX_POINTS_DEF * MAX_CHANNELS_DEF;
	localparam int DRAIN_CYCLES   = 100;
	localparam int CYCLE_LIMIT    = 2_000_000;
	localparam int RANDOM_ITEMS   = 1000;
	localparam int HOLD_AT_RESULT = 300;
	localparam int HOLD_CYCLES    = 400;

	localparam logic [SAMPLE_W-1:0] EDGE_VALS [4] = '{
		32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff
	};
	localparam logic [SAMPLE_W-1:0] ALT_VALS [8] = '{
		32'h7fff_ffff, 32'h8000_0000, 32'hffff_fff9, 32'h0000_0007,
		32'h8000_0000, 32'h7fff_ffff, 32'h0000_0003, 32'hffff_fffd
	};

	typedef struct packed {
		logic [SAMPLE_W-1:0] total;
		logic [IDX_W-1:0]    pos_idx;
		logic                frame_end;
	} sum_item_t;

	class stack_scoreboard;
		logic [PTS_CFG_W-1:0] points_reg;
		logic [CH_CFG_W-1:0]  chans_reg;
		logic [SW_CFG_W-1:0]  sweeps_reg;
		logic                 alt_reg;
		logic [SAMPLE_W-1:0]  acc [ACC_DEPTH];
		int unsigned          pos;
		logic [SW_CFG_W-1:0]  sweep_no;
		sum_item_t            pending_sums[$];
		int                   errors;

		function new();
			points_reg = PTS_RST;
			chans_reg  = CH_RST;
			sweeps_reg = SW_RST;
			alt_reg    = 1'b0;
			foreach (acc[i]) acc[i] = '0;
			pos      = 0;
			sweep_no = '0;
			errors   = 0;
		endfunction

		function void write_reg(cfg_reg_t r, logic [CFG_W-1:0] d);
			case (r)
			REG_POINTS:   points_reg = d[PTS_CFG_W-1:0];
			REG_CHANNELS: chans_reg  = d[CH_CFG_W-1:0];
			REG_SWEEPS:   sweeps_reg = d[SW_CFG_W-1:0];
			REG_ALT:      alt_reg    = d[0];
			default: ;
			endcase
		endfunction

		function void note_sample(logic [SAMPLE_W-1:0] x);
			int unsigned         npts, nch, nsw, flen;
			logic [SAMPLE_W-1:0] mag, quot;
			logic                last_sweep;
			sum_item_t           s;
			npts = (points_reg == 0) ? 1 :
				(points_reg > MAX_POINTS_DEF) ? MAX_POINTS_DEF : points_reg;
			nch  = (chans_reg == 0) ? 1 :
				(chans_reg > MAX_CHANNELS_DEF) ? MAX_CHANNELS_DEF : chans_reg;
			nsw  = (sweeps_reg == 0) ? 1 : sweeps_reg;
			flen = npts * nch;
			if (pos >= flen)
				pos = 0;
			// divide magnitude, restore sign: truncates toward zero
			mag  = x[SAMPLE_W-1] ? -x : x;
			quot = mag / nsw;
			if (x[SAMPLE_W-1])
				quot = -quot;
			if (alt_reg && sweep_no[0])
				acc[pos] = acc[pos] - quot;
			else
				acc[pos] = acc[pos] + quot;
			last_sweep = (32'(sweep_no) + 32'd1) >= nsw;
			if (last_sweep) begin
				s.total     = acc[pos];
				s.pos_idx   = IDX_W'(pos);
				s.frame_end = (pos + 1 == flen);
				pending_sums.push_back(s);
				acc[pos] = '0;
			end
			pos++;
			if (pos >= flen) begin
				pos      = 0;
				sweep_no = last_sweep ? '0 : sweep_no + 1'b1;
			end
		endfunction

		function void check_sum(logic [SAMPLE_W-1:0] got_sum, logic [IDX_W-1:0] got_idx,
				logic got_last);
			sum_item_t want;
			if (pending_sums.size() == 0) begin
				errors++;
				$display("%0t: unexpected sum_word %h word_index %0d", $time, got_sum, got_idx);
				return;
			end
			want = pending_sums.pop_front();
			if (got_sum !== want.total) begin
				errors++;
				$display("%0t: sum_word expected %h actual %h", $time, want.total, got_sum);
			end
			if (got_idx !== want.pos_idx) begin
				errors++;
				$display("%0t: word_index expected %0d actual %0d", $time, want.pos_idx,
					got_idx);
			end
			if (got_last !== want.frame_end) begin
				errors++;
				$display("%0t: frame_last expected %b actual %b", $time, want.frame_end,
					got_last);
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	cfg_reg_t            cfg_index;
	logic [CFG_W-1:0]    cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic [SAMPLE_W-1:0] sample;
	logic                out_valid;
	logic                out_ready;
	logic [SAMPLE_W-1:0] sum_word;
	logic [IDX_W-1:0]    word_index;
	logic                frame_last;

	stack_scoreboard sb;
	int              burst_left = 0;
	int              results_seen = 0;
	int              cycle_count = 0;

	sweep_stack_averager i_dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_sum(sum_word, word_index, frame_last);
			results_seen++;
		end
	end

	// receiver: random ready patterns, plus one long hold to back up the block
	initial begin
		int mode, left, tick;
		bit held;
		out_ready = 1'b0;
		mode = 0;
		left = 0;
		tick = 0;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!held && results_seen >= HOLD_AT_RESULT) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(20, 200);
			end
			left--;
			tick++;
			case (mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= ($urandom_range(0, 7) == 0);
			default: out_ready <= ((tick % 5) < 2);
			endcase
		end
	end

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 9))
		0: return 32'h8000_0000;
		1: return 32'h7fff_ffff;
		2: return $urandom_range(0, 200) - 100;
		default: return $urandom;
		endcase
	endfunction

	task automatic write_cfg(cfg_reg_t r, logic [CFG_W-1:0] d);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= r;
		cfg_data  <= d;
		sb.write_reg(r, d);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		while (sb.pending_sums.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic new_phase(logic [CFG_W-1:0] pts, logic [CFG_W-1:0] chs,
			logic [CFG_W-1:0] sws, logic alt);
		wait_idle();
		write_cfg(REG_POINTS, pts);
		write_cfg(REG_CHANNELS, chs);
		write_cfg(REG_SWEEPS, sws);
		write_cfg(REG_ALT, {{(CFG_W-1){1'b0}}, alt});
	endtask

	// one item; valid stays up inside a burst, drops for a random gap between bursts
	task automatic feed(logic [SAMPLE_W-1:0] x);
		in_valid <= 1'b1;
		sample   <= x;
		do @(posedge clk); while (!in_ready);
		sb.note_sample(x);
		if (burst_left > 0)
			burst_left--;
		else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 45)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150) :
				$urandom_range(0, 12);
		end
	endtask

	task automatic stop_feed();
		in_valid <= 1'b0;
	endtask

	initial begin
		int pts, chs, sws, n, done_items;
		sb = new();
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_POINTS;
		cfg_data  = '0;
		in_valid  = 1'b0;
		sample    = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// zero-valued registers act as one; extreme samples with divisor one
		new_phase(CFG_W'(0), CFG_W'(0), CFG_W'(0), 1'b0);
		for (int i = 0; i < 4; i++)
			feed(EDGE_VALS[i]);
		stop_feed();

		// two sweeps over two points of two channels, second sweep subtracted
		new_phase(CFG_W'(2), CFG_W'(2), CFG_W'(2), 1'b1);
		for (int i = 0; i < 8; i++)
			feed(ALT_VALS[i]);
		stop_feed();

		// largest divisor, then shrink the group below the sweep count
		new_phase(CFG_W'(1), CFG_W'(1), 16'hffff, 1'b0);
		feed(32'h7fff_ffff);
		feed(32'h8000_0000);
		feed(32'd327675);
		stop_feed();
		new_phase(CFG_W'(1), CFG_W'(1), CFG_W'(2), 1'b0);
		feed(32'hffff_0001);
		stop_feed();

		// partial sweep, frame shrinks under the position, then grows back
		new_phase(CFG_W'(3), CFG_W'(1), CFG_W'(2), 1'b0);
		repeat (2) feed(rand_sample());
		stop_feed();
		new_phase(CFG_W'(1), CFG_W'(1), CFG_W'(2), 1'b0);
		repeat (2) feed(rand_sample());
		stop_feed();
		new_phase(CFG_W'(3), CFG_W'(1), CFG_W'(2), 1'b0);
		repeat (6) feed(rand_sample());
		stop_feed();

		// oversized registers clamp: points alone, then channels alone
		new_phase(CFG_W'(1023), CFG_W'(1), CFG_W'(1), 1'b1);
		repeat (MAX_POINTS_DEF) feed(rand_sample());
		stop_feed();
		new_phase(CFG_W'(1), CFG_W'(15), CFG_W'(1), 1'b1);
		repeat (MAX_CHANNELS_DEF) feed(rand_sample());
		stop_feed();

		done_items = 0;
		while (done_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 7) == 0) begin
				new_phase(CFG_W'($urandom_range(0, 1023)), CFG_W'($urandom_range(0, 15)),
					CFG_W'($urandom), 1'($urandom_range(0, 1)));
				n = $urandom_range(1, 40);
			end else begin
				pts = $urandom_range(1, 6);
				chs = $urandom_range(1, 4);
				sws = $urandom_range(1, 4);
				new_phase(CFG_W'(pts), CFG_W'(chs), CFG_W'(sws), 1'($urandom_range(0, 1)));
				n = pts * chs * sws * $urandom_range(1, 3);
				if ($urandom_range(0, 4) == 0)
					n += $urandom_range(1, pts * chs);
			end
			repeat (n) feed(rand_sample());
			stop_feed();
			done_items += n;
		end

		wait_idle();
		if (sb.errors == 0 && sb.pending_sums.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
